/* design/bvs_pkg.sv */
package bvs_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned ValueWidth = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } bvs_state_e;

  typedef struct packed {
    logic                  valid;
    logic [ValueWidth-1:0] value;
  } bvs_slot_t;

  typedef struct packed {
    logic                  insert;
    logic                  shift;
    logic [ValueWidth-1:0] x;
  } bvs_ctl_t;

  typedef struct packed {
    logic head_valid;
    logic second_valid;
    logic full;
  } bvs_stat_t;

endpackage

/* design/block_value_sorter_core.sv */
// channel | dir | tdata                 | tlast    | tuser
// s_axis  | in  | [31:0] value (signed) | last     | -
// m_axis  | out | [31:0] value_res      | last_res | overflow
//
// Loading takes one item a cycle; each value enters a row of Depth cells at once.
// After the closing item the set drains from the head cell, one item a cycle
// while m_axis is ready, starting the next cycle. No input is taken while
// draining. m_axis stalls hold the head cell.
// Reset clears the cell valid bits and the overflow flag.
module block_value_sorter_core
  import bvs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [ValueWidth-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [ValueWidth-1:0] m_axis_tdata_o,  // [31:0] value_res
  output logic                  m_axis_tlast_o,
  output logic                  m_axis_tuser_o   // [0] overflow
);

  bvs_ctl_t        ctl;
  bvs_stat_t       stat;
  bvs_slot_t       slot    [Depth];
  logic            ins     [Depth];
  logic [Depth-1:0] valid_vec;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    bvs_slot_t prev_slot, next_slot;
    logic      prev_ins;

    if (i == 0) begin : g_head
      assign prev_slot = '0;
      assign prev_ins  = 1'b0;
    end else begin : g_body
      assign prev_slot = slot[i-1];
      assign prev_ins  = ins[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_mid
      assign next_slot = slot[i+1];
    end

    bvs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .prev_slot_i (prev_slot),
      .prev_ins_i  (prev_ins),
      .next_slot_i (next_slot),
      .slot_o      (slot[i]),
      .ins_o       (ins[i])
    );

    assign valid_vec[i] = slot[i].valid;
  end

  assign stat.head_valid   = slot[0].valid;
  assign stat.second_valid = slot[1].valid;
  assign stat.full         = slot[Depth-1].valid;

  bvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_value_i  (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_last_o  (m_axis_tlast_o),
    .overflow_o  (m_axis_tuser_o),
    .ctl_o       (ctl)
  );

  assign m_axis_tdata_o = slot[0].value;

  // occupied cells always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + Depth'(1))) == '0)
    else $error("cell occupancy not contiguous");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && slot[1].valid |-> $signed(slot[0].value) <= $signed(slot[1].value))
    else $error("head cells out of order");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("load and drain overlap");

  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("closing item gave no result");

endmodule

/* design/bvs_cell.sv */
module bvs_cell
  import bvs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bvs_ctl_t  ctl_i,
  input  bvs_slot_t prev_slot_i,
  input  logic      prev_ins_i,
  input  bvs_slot_t next_slot_i,
  output bvs_slot_t slot_o,
  output logic      ins_o
);

  logic                  valid_q, valid_d;
  logic [ValueWidth-1:0] value_q, value_d;

  // strict compare keeps equal values in arrival order
  assign ins_o  = !valid_q || ($signed(ctl_i.x) < $signed(value_q));
  assign slot_o = '{valid: valid_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctl_i.insert && ins_o) begin
      if (prev_ins_i) begin
        valid_d = prev_slot_i.valid;
        value_d = prev_slot_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = ctl_i.x;
      end
    end else if (ctl_i.shift) begin
      valid_d = next_slot_i.valid;
      value_d = next_slot_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* design/bvs_ctrl.sv */
module bvs_ctrl
  import bvs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  input  logic [ValueWidth-1:0] in_value_i,
  input  logic                  out_ready_i,
  input  bvs_stat_t             stat_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output logic                  out_last_o,
  output logic                  overflow_o,
  output bvs_ctl_t              ctl_o
);

  bvs_state_e state_q, state_d;
  logic       dropped_q, dropped_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && in_last_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && !stat_i.second_valid) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    dropped_d = dropped_q;
    if (in_acc && stat_i.full) dropped_d = 1'b1;
    if (out_acc && !stat_i.second_valid) dropped_d = 1'b0;
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD:  in_ready_o  = 1'b1;
      ST_DRAIN: out_valid_o = stat_i.head_valid;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    out_last_o   = !stat_i.second_valid;
    overflow_o   = dropped_q;
    ctl_o.insert = in_acc && !stat_i.full;
    ctl_o.shift  = out_acc;
    ctl_o.x      = in_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

/* tb/sv/block_value_sorter_core_chk.sv */
module block_value_sorter_core_chk
  import bvs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [ValueWidth-1:0] s_tdata_i,
  input  logic                  s_tlast_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [ValueWidth-1:0] m_tdata_i,
  input  logic                  m_tlast_i,
  input  logic                  m_tuser_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  last;
    logic                  overflow;
  } sorted_item_t;

  sorted_item_t                 sorted_q[$];
  logic signed [ValueWidth-1:0] held_set [Depth];
  int unsigned                  held_n    = 0;
  logic                         set_lossy = 1'b0;
  int                           fails     = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin : watch
    sorted_item_t                 want;
    logic signed [ValueWidth-1:0] key;
    int                           j;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected item: value_res %0d", $signed(m_tdata_i));
          fails++;
        end else begin
          want = sorted_q.pop_front();
          if (m_tdata_i !== want.value) begin
            $error("value_res: expected %0d, got %0d", $signed(want.value), $signed(m_tdata_i));
            fails++;
          end
          if (m_tlast_i !== want.last) begin
            $error("last_res: expected %0b, got %0b", want.last, m_tlast_i);
            fails++;
          end
          if (m_tuser_i !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, m_tuser_i);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (held_n < Depth) begin
          held_set[held_n] = s_tdata_i;
          held_n++;
        end else begin
          set_lossy = 1'b1;
        end
        if (s_tlast_i) begin
          // stable insertion: only strictly larger values move up
          for (int i = 1; i < held_n; i++) begin
            key = held_set[i];
            j   = i;
            while (j > 0 && held_set[j-1] > key) begin
              held_set[j] = held_set[j-1];
              j--;
            end
            held_set[j] = key;
          end
          for (int i = 0; i < held_n; i++) begin
            want.value    = held_set[i];
            want.last     = (i == held_n - 1);
            want.overflow = set_lossy;
            sorted_q.push_back(want);
          end
          held_n    = 0;
          set_lossy = 1'b0;
        end
      end
    end
    fail_count_o = fails;
    pending_o    = sorted_q.size();
  end

endmodule

/* tb/sv/block_value_sorter_core_tb.sv */
module block_value_sorter_core_tb;
  import bvs_pkg::*;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  s_valid = 1'b0;
  logic [ValueWidth-1:0] s_data  = '0;
  logic                  s_last  = 1'b0;
  logic                  m_ready = 1'b0;
  logic                  s_ready;
  logic                  m_valid;
  logic [ValueWidth-1:0] m_data;
  logic                  m_last;
  logic                  m_user;

  int fail_count;
  int pending;
  int sent       = 0;
  bit pacing_on  = 1'b1;
  bit pressured  = 1'b0;

  always #4 clk_i = ~clk_i;

  block_value_sorter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  block_value_sorter_core_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tlast_i    (s_last),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tlast_i    (m_last),
    .m_tuser_i    (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk_i) begin
    m_ready <= !pacing_on || ($urandom_range(99) >= 37);
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_value(input logic [ValueWidth-1:0] v, input logic lst);
    while (pacing_on && $urandom_range(99) < 37) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= v;
    s_last  <= lst;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [ValueWidth-1:0] pick_value(input int unsigned mode);
    logic [ValueWidth-1:0] v;
    case (mode)
      1: v = $urandom_range(8) - 4;  // narrow spread, many ties
      2: begin
        case ($urandom_range(3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_set(input int unsigned size, input int unsigned mode);
    for (int i = 0; i < size; i++) begin
      push_value(pick_value(mode), i == size - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned size;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_value(32'h8000_0000, 1'b1);
    push_value(32'h7fff_ffff, 1'b1);
    push_value(32'd5, 1'b0);
    push_value(32'hffff_ffff, 1'b0);
    push_value(32'h7fff_ffff, 1'b0);
    push_value(32'd5, 1'b0);
    push_value(32'h8000_0000, 1'b0);
    push_value(32'd0, 1'b0);
    push_value(32'd5, 1'b1);
    wait_drained();

    while (sent < 230) begin
      r = $urandom_range(99);
      if (r < 12) begin
        size = $urandom_range(Depth + 4, Depth + 1);
      end else if (r < 24) begin
        size = Depth;
      end else begin
        size = $urandom_range(Depth - 1, 1);
      end
      pacing_on = !(sent >= 100 && sent < 160);
      send_set(size, $urandom_range(3));
      if (!pressured && sent >= 170) begin
        wait_drained();
        pressured = 1'b1;
      end
    end

    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * Depth + 8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("block_value_sorter_core_tb: clean");
    end else begin
      $display("block_value_sorter_core_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("block_value_sorter_core_tb: errors");
    $finish;
  end

endmodule
